/* rtl/bcd_clock_to_epoch_core_assert.svh */
// Assertion macros used by the checker file.
`ifndef BCD_CLOCK_TO_EPOCH_CORE_ASSERT_SVH
`define BCD_CLOCK_TO_EPOCH_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define BCE_AST_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define BCE_AST_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

// Same-cycle implication that stays live through reset.
`define BCE_AST_ALWAYS(lbl, ck, ante, cons, msg) \
	lbl: assert property (@(posedge ck) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/bce_pkg.sv */
package bce_pkg;

	localparam int EPOCH_W   = 34;
	localparam int CFG_IDX_W = 1;
	localparam int DAYS_W    = 17;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_EPOCH = 1'b0,
		CFG_MAX_EPOCH = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		RC_OK          = 2'd0,
		RC_OSC_STOP    = 2'd1,
		RC_RANGE       = 2'd2,
		RC_IMPLAUSIBLE = 2'd3
	} rc_t;

	localparam logic [EPOCH_W-1:0] MIN_EPOCH_RST = 34'd946684800;
	localparam logic [EPOCH_W-1:0] MAX_EPOCH_RST = 34'd7258118399;

	// 1970-01-01 to 2000-01-01
	localparam logic [DAYS_W-1:0] DAYS_TO_2000 = 17'd10957;
	localparam logic [DAYS_W-1:0] SEC_PER_DAY  = 17'd86400;

	typedef struct packed {
		logic [7:0] status;
		logic [7:0] sec;
		logic [7:0] minute;
		logic [7:0] hour;
		logic [7:0] date;
		logic [7:0] mon_cent;
		logic [7:0] year;
	} snap_t;

	typedef struct packed {
		rc_t        rc;
		logic [8:0] yoff;     // years past 2000, 0..265
		logic [3:0] mon;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} dec_t;

	typedef struct packed {
		rc_t              rc;
		logic [DAYS_W-1:0] days;
		logic [DAYS_W-1:0] tod;
	} cal_t;

	// Unchecked BCD: high nibble times ten plus low nibble.
	function automatic logic [7:0] bcd_dec(input logic [7:0] v);
		logic [7:0] hi;
		hi = {4'd0, v[7:4]};
		return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
	endfunction

	// Days before the first of the month in a common year.
	function automatic logic [8:0] month_start(input logic [3:0] mon);
		logic [8:0] d;
		case (mon)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

/* rtl/bce_decode.sv */
module bce_decode (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bce_pkg::snap_t in_snap,
	output logic          out_valid,
	input  logic          out_ready,
	output bce_pkg::dec_t out_dec
);
	import bce_pkg::*;

	logic [7:0] sec_d, min_d, hour_d, day_d, mon_d, year_d;
	logic       range_bad;
	dec_t       dec;
	logic       valid_s1;
	dec_t       dec_s1;

	always_comb begin
		sec_d  = bcd_dec({1'b0, in_snap.sec[6:0]});
		min_d  = bcd_dec({1'b0, in_snap.minute[6:0]});
		hour_d = bcd_dec({2'b0, in_snap.hour[5:0]});
		day_d  = bcd_dec({2'b0, in_snap.date[5:0]});
		mon_d  = bcd_dec({3'b0, in_snap.mon_cent[4:0]});
		year_d = bcd_dec(in_snap.year);

		range_bad = (mon_d == 8'd0) || (mon_d > 8'd12) || (day_d == 8'd0) ||
			(day_d > 8'd31) || (hour_d > 8'd23) || (min_d > 8'd59) || (sec_d > 8'd59);

		// oscillator stop outranks a bad field
		if (in_snap.status[7]) begin
			dec.rc = RC_OSC_STOP;
		end else if (range_bad) begin
			dec.rc = RC_RANGE;
		end else begin
			dec.rc = RC_OK;
		end
		dec.yoff   = {1'b0, year_d} + (in_snap.mon_cent[7] ? 9'd100 : 9'd0);
		dec.mon    = mon_d[3:0];
		dec.day    = day_d[4:0];
		dec.hour   = hour_d[4:0];
		dec.minute = min_d[5:0];
		dec.second = sec_d[5:0];
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dec_s1 <= dec;
		end
	end

	assign out_valid = valid_s1;
	assign out_dec   = dec_s1;

endmodule

/* rtl/bce_calendar.sv */
module bce_calendar (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bce_pkg::dec_t in_dec,
	output logic          out_valid,
	input  logic          out_ready,
	output bce_pkg::cal_t out_cal
);
	import bce_pkg::*;

	logic [8:0]        yp3;
	logic [6:0]        leaps;
	logic              is_leap;
	logic              leap_adj;
	cal_t              cal;
	logic              valid_s2;
	cal_t              cal_s2;

	always_comb begin
		// leap days in [2000, 2000+yoff); 2100 and 2200 are common years
		yp3      = in_dec.yoff + 9'd3;
		leaps    = yp3[8:2] - 7'(in_dec.yoff > 9'd100) - 7'(in_dec.yoff > 9'd200);
		is_leap  = (in_dec.yoff[1:0] == 2'b00) && (in_dec.yoff != 9'd100) &&
			(in_dec.yoff != 9'd200);
		leap_adj = is_leap && (in_dec.mon > 4'd2);

		cal.rc   = in_dec.rc;
		cal.days = DAYS_TO_2000 + 17'(in_dec.yoff) * 17'd365 + 17'(leaps) +
			17'(month_start(in_dec.mon)) + 17'(leap_adj) + 17'(in_dec.day) - 17'd1;
		cal.tod  = 17'(in_dec.hour) * 17'd3600 + 17'(in_dec.minute) * 17'd60 +
			17'(in_dec.second);
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cal_s2 <= cal;
		end
	end

	assign out_valid = valid_s2;
	assign out_cal   = cal_s2;

endmodule

/* rtl/bce_epoch.sv */
module bce_epoch (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  bce_pkg::cal_t                in_cal,
	input  logic [bce_pkg::EPOCH_W-1:0]  min_epoch,
	input  logic [bce_pkg::EPOCH_W-1:0]  max_epoch,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bce_pkg::EPOCH_W-1:0]  out_secs,
	output bce_pkg::rc_t                 out_rc
);
	import bce_pkg::*;

	logic               valid_s3;
	rc_t                rc_s3;
	logic [EPOCH_W-1:0] prod_s3;
	logic [DAYS_W-1:0]  tod_s3;
	logic               ready_s4;

	logic [EPOCH_W-1:0] sum;
	logic [EPOCH_W-1:0] epoch_nx;
	rc_t                rc_nx;

	logic               valid_s4;
	logic [EPOCH_W-1:0] epoch_s4;
	rc_t                rc_s4;

	// stage 3: whole days to seconds
	assign in_ready = !valid_s3 || ready_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rc_s3   <= in_cal.rc;
			prod_s3 <= EPOCH_W'(in_cal.days) * EPOCH_W'(SEC_PER_DAY);
			tod_s3  <= in_cal.tod;
		end
	end

	// stage 4: add time of day, window check, output register
	always_comb begin
		sum = prod_s3 + EPOCH_W'(tod_s3);
		if (rc_s3 != RC_OK) begin
			rc_nx    = rc_s3;
			epoch_nx = '0;
		end else if ((sum < min_epoch) || (sum > max_epoch)) begin
			rc_nx    = RC_IMPLAUSIBLE;
			epoch_nx = '0;
		end else begin
			rc_nx    = RC_OK;
			epoch_nx = sum;
		end
	end

	assign ready_s4 = !valid_s4 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			epoch_s4 <= epoch_nx;
			rc_s4    <= rc_nx;
		end
	end

	assign out_valid = valid_s4;
	assign out_secs  = epoch_s4;
	assign out_rc    = rc_s4;

endmodule

/* rtl/bcd_clock_to_epoch_core.sv */
// Throughput: one snapshot per cycle when m_tready does not stall the output;
// four register stages (decode, calendar, day scaling, add and window check),
// each holding one request.
// Reset: arst_n clears every stage valid bit at once and loads the plausibility
// window with its defaults; no clearing pass.
module bcd_clock_to_epoch_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// status, seconds, minutes, hours, date, month_century, year (bits 7:0 up)
	input  logic [55:0]                     s_tdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// epoch_seconds [33:0], zero fill [39:34]
	output logic [39:0]                     m_tdata,
	// result_code [1:0]
	output logic [1:0]                      m_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bce_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bce_pkg::EPOCH_W-1:0]     cfg_data
);
	import bce_pkg::*;

	logic [EPOCH_W-1:0] min_epoch_q;
	logic [EPOCH_W-1:0] max_epoch_q;

	snap_t              snap;
	logic               dec_valid, dec_ready;
	dec_t               dec;
	logic               cal_valid, cal_ready;
	cal_t               cal;
	logic [EPOCH_W-1:0] epoch;
	rc_t                rc;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_epoch_q <= MIN_EPOCH_RST;
			max_epoch_q <= MAX_EPOCH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MIN_EPOCH: min_epoch_q <= cfg_data;
				CFG_MAX_EPOCH: max_epoch_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		snap.status   = s_tdata[7:0];
		snap.sec      = s_tdata[15:8];
		snap.minute   = s_tdata[23:16];
		snap.hour     = s_tdata[31:24];
		snap.date     = s_tdata[39:32];
		snap.mon_cent = s_tdata[47:40];
		snap.year     = s_tdata[55:48];
	end

	bce_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_snap   (snap),
		.out_valid (dec_valid),
		.out_ready (dec_ready),
		.out_dec   (dec)
	);

	bce_calendar u_calendar (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dec_valid),
		.in_ready  (dec_ready),
		.in_dec    (dec),
		.out_valid (cal_valid),
		.out_ready (cal_ready),
		.out_cal   (cal)
	);

	bce_epoch u_epoch (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cal_valid),
		.in_ready  (cal_ready),
		.in_cal    (cal),
		.min_epoch (min_epoch_q),
		.max_epoch (max_epoch_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_secs  (epoch),
		.out_rc    (rc)
	);

	assign m_tdata = {6'd0, epoch};
	assign m_tuser = rc;

endmodule

/* rtl/bce_checker.sv */
`include "bcd_clock_to_epoch_core_assert.svh"

module bce_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [39:0]                   m_tdata,
	input logic [1:0]                    m_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready
);
	import bce_pkg::*;

	`BCE_AST_ALWAYS(a_rst_empty, clk, !arst_n, !m_tvalid, "result valid during reset")

	`BCE_AST_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	`BCE_AST_SAME(a_err_zero, clk, arst_n, m_tvalid && (m_tuser != RC_OK), m_tdata == 40'd0, "error result with nonzero epoch")

	// with the output slot free every stage can move, so input must be open
	`BCE_AST_SAME(a_no_block, clk, arst_n, !m_tvalid || m_tready, s_tready, "input blocked with output free")

	// pad bits are zero on a valid result while the input is also valid
	`BCE_AST_SAME(a_pad_zero, clk, arst_n, m_tvalid && s_tvalid, m_tdata[39:34] == 6'd0, "nonzero pad bits")

endmodule

bind bcd_clock_to_epoch_core bce_checker u_bce_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

/* verif/tb_bcd_clock_to_epoch_core.sv */
module tb_bcd_clock_to_epoch_core;
	timeunit 1ns;
	timeprecision 1ps;

	import bce_pkg::*;

	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		rc_t                rc;
	} epoch_reading_t;

	localparam logic [EPOCH_W-1:0] EPOCH_ALL_ONES = {EPOCH_W{1'b1}};
	localparam int RANDOM_PER_PHASE = 330;

	logic                 clk;
	logic                 arst_n;
	logic [55:0]          s_tdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [39:0]          m_tdata;
	logic [1:0]           m_tuser;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	cfg_idx_t             cfg_index = CFG_MIN_EPOCH;
	logic [EPOCH_W-1:0]   cfg_data = '0;

	// window as the block should currently hold it
	logic [EPOCH_W-1:0]   window_lo = MIN_EPOCH_RST;
	logic [EPOCH_W-1:0]   window_hi = MAX_EPOCH_RST;

	logic [55:0]          snapshots_to_send[$];
	epoch_reading_t       pending_readings[$];
	epoch_reading_t       oldest_reading;
	int unsigned          src_idle_pct = 26;
	int unsigned          rx_idle_pct = 47;
	logic                 rx_hold = 1'b0;
	int unsigned          errors = 0;

	bcd_clock_to_epoch_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	function automatic int unsigned bcd_value(logic [7:0] v);
		return v[7:4] * 10 + v[3:0];
	endfunction

	function automatic logic [7:0] to_bcd(int unsigned n);
		return {4'(n / 10), 4'(n % 10)};
	endfunction

	function automatic logic [55:0] snapshot(logic [7:0] st, logic [7:0] sec,
			logic [7:0] mnt, logic [7:0] hr, logic [7:0] dt, logic [7:0] mc,
			logic [7:0] yr);
		return {yr, mc, dt, hr, mnt, sec, st};
	endfunction

	function automatic epoch_reading_t convert_snapshot(logic [55:0] snap,
			logic [EPOCH_W-1:0] lo, logic [EPOCH_W-1:0] hi);
		epoch_reading_t r;
		int unsigned sec, mnt, hr, dy, mo, yr, y, era, yoe, mp, doy, doe;
		longint unsigned days, secs;
		r.epoch = '0;
		if (snap[7]) begin
			r.rc = RC_OSC_STOP;
			return r;
		end
		sec = bcd_value(snap[15:8] & 8'h7F);
		mnt = bcd_value(snap[23:16] & 8'h7F);
		hr  = bcd_value(snap[31:24] & 8'h3F);
		dy  = bcd_value(snap[39:32] & 8'h3F);
		mo  = bcd_value(snap[47:40] & 8'h1F);
		yr  = 2000 + bcd_value(snap[55:48]) + (snap[47] ? 100 : 0);
		if (mo < 1 || mo > 12 || dy < 1 || dy > 31 || hr > 23 || mnt > 59 || sec > 59) begin
			r.rc = RC_RANGE;
			return r;
		end
		// March-based year so the leap day falls at the end
		y    = yr - (mo <= 2 ? 1 : 0);
		era  = y / 400;
		yoe  = y - era * 400;
		mp   = (mo > 2) ? mo - 3 : mo + 9;
		doy  = (153 * mp + 2) / 5 + dy - 1;
		doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		days = longint'(era) * 146097 + doe - 719468;
		secs = days * 86400 + hr * 3600 + mnt * 60 + sec;
		if (secs < lo || secs > hi) begin
			r.rc = RC_IMPLAUSIBLE;
			return r;
		end
		r.epoch = secs[EPOCH_W-1:0];
		r.rc = RC_OK;
		return r;
	endfunction

	function automatic logic [55:0] random_snapshot();
		logic [7:0] f [7];
		int unsigned kind;
		kind = $urandom_range(99);
		// well-formed reading, ignored bits random
		f[0] = 8'($urandom & 8'h7F);
		f[1] = to_bcd($urandom_range(59)) | 8'($urandom & 8'h80);
		f[2] = to_bcd($urandom_range(59)) | 8'($urandom & 8'h80);
		f[3] = to_bcd($urandom_range(23)) | 8'($urandom & 8'hC0);
		f[4] = to_bcd($urandom_range(31, 1)) | 8'($urandom & 8'hC0);
		f[5] = to_bcd($urandom_range(12, 1)) | 8'($urandom & 8'hE0);
		f[6] = to_bcd($urandom_range(99));
		if (kind < 5) begin
			f[0] = f[0] | 8'h80;
		end else if (kind < 15) begin
			for (int i = 0; i < 7; i++)
				f[i] = 8'($urandom);
			f[0][7] = 1'b0;
		end else if (kind < 25) begin
			f[$urandom_range(6, 1)] = 8'($urandom);
		end
		return {f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
	endfunction

	task automatic cfg_write(cfg_idx_t idx, logic [EPOCH_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_MIN_EPOCH)
			window_lo = value;
		else
			window_hi = value;
	endtask

	task automatic wait_idle();
		while (snapshots_to_send.size() != 0 || s_tvalid || pending_readings.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++)
			snapshots_to_send.push_back(random_snapshot());
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("[bcd_clock_to_epoch_core] ERROR");
		$finish;
	end

	// sender: one request per accepted item, random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				pending_readings.push_back(convert_snapshot(s_tdata, window_lo, window_hi));
			if (!s_tvalid || s_tready) begin
				if (snapshots_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					s_tdata  <= snapshots_to_send.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each result against the oldest expected reading
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_readings.size() == 0) begin
					$display("%0t: unexpected result, expected none, got epoch %0d code %0d",
						$time, m_tdata, m_tuser);
					errors++;
				end else begin
					oldest_reading = pending_readings.pop_front();
					if (m_tdata !== {6'd0, oldest_reading.epoch}) begin
						$display("%0t: epoch mismatch, expected %0d, got %0d",
							$time, oldest_reading.epoch, m_tdata);
						errors++;
					end
					if (m_tuser !== oldest_reading.rc) begin
						$display("%0t: result code mismatch, expected %0d, got %0d",
							$time, oldest_reading.rc, m_tuser);
						errors++;
					end
				end
			end
			m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		logic [EPOCH_W-1:0] target, lo;
		epoch_reading_t     target_rd;
		// a real falling edge so the asynchronous resets fire before the first clock
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed readings under the reset window
		snapshots_to_send.push_back(snapshot(8'h80, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00));
		snapshots_to_send.push_back(snapshot(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		snapshots_to_send.push_back(snapshot(8'h7F, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00));
		snapshots_to_send.push_back(snapshot(8'h00, 8'h59, 8'h59, 8'h23, 8'h31, 8'h92, 8'h99));
		snapshots_to_send.push_back(snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h81, 8'h00));
		snapshots_to_send.push_back(snapshot(8'h00, 8'h59, 8'h59, 8'h23, 8'h31, 8'h92, 8'hFF));
		// leap days: 2000 is leap, 2100 is not
		snapshots_to_send.push_back(snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00));
		snapshots_to_send.push_back(snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h29, 8'h82, 8'h00));
		// day past month end rolls into March
		snapshots_to_send.push_back(snapshot(8'h00, 8'h00, 8'h00, 8'h12, 8'h31, 8'h02, 8'h23));
		snapshots_to_send.push_back(snapshot(8'h00, 8'h00, 8'h00, 8'h12, 8'h31, 8'h02, 8'h24));
		// out of range fields
		snapshots_to_send.push_back(snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h10));
		snapshots_to_send.push_back(snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h10));
		snapshots_to_send.push_back(snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h1F, 8'h10));
		snapshots_to_send.push_back(snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h10));
		snapshots_to_send.push_back(snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h32, 8'h05, 8'h10));
		snapshots_to_send.push_back(snapshot(8'h00, 8'h00, 8'h00, 8'h24, 8'h01, 8'h05, 8'h10));
		snapshots_to_send.push_back(snapshot(8'h00, 8'h00, 8'h60, 8'h00, 8'h01, 8'h05, 8'h10));
		snapshots_to_send.push_back(snapshot(8'h00, 8'h60, 8'h00, 8'h00, 8'h01, 8'h05, 8'h10));
		snapshots_to_send.push_back(snapshot(8'h00, 8'h7F, 8'h00, 8'h00, 8'h01, 8'h05, 8'h10));
		snapshots_to_send.push_back(snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h3F, 8'h05, 8'h10));
		// bad nibbles that still decode in range
		snapshots_to_send.push_back(snapshot(8'h00, 8'h4F, 8'h0A, 8'h1D, 8'h1F, 8'h0A, 8'hAF));
		// ignored high bits set everywhere
		snapshots_to_send.push_back(snapshot(8'h7F, 8'hD9, 8'hB0, 8'hE3, 8'hF1, 8'h6C, 8'h42));

		for (int phase = 0; phase < 6; phase++) begin
			wait_idle();
			src_idle_pct <= (phase < 2) ? 26 : (phase < 4) ? 47 : 0;
			rx_idle_pct  <= (phase < 2) ? 47 : (phase < 4) ? 26 : 0;
			case (phase)
				0: begin
					cfg_write(CFG_MIN_EPOCH, '0);
					cfg_write(CFG_MAX_EPOCH, EPOCH_ALL_ONES);
				end
				1: begin
					lo = MIN_EPOCH_RST + $urandom_range(2_000_000_000);
					cfg_write(CFG_MIN_EPOCH, lo);
					cfg_write(CFG_MAX_EPOCH, lo + $urandom_range(3_000_000_000));
				end
				2: begin
					// inverted window rejects every reading
					cfg_write(CFG_MIN_EPOCH, MAX_EPOCH_RST);
					cfg_write(CFG_MAX_EPOCH, MIN_EPOCH_RST);
				end
				3: begin
					target_rd = convert_snapshot(
						snapshot(8'h00, 8'h56, 8'h34, 8'h12, 8'h29, 8'h02, 8'h24),
						'0, EPOCH_ALL_ONES);
					target = target_rd.epoch;
					cfg_write(CFG_MIN_EPOCH, target);
					cfg_write(CFG_MAX_EPOCH, target);
					snapshots_to_send.push_back(
						snapshot(8'h00, 8'h56, 8'h34, 8'h12, 8'h29, 8'h02, 8'h24));
					snapshots_to_send.push_back(
						snapshot(8'h00, 8'h55, 8'h34, 8'h12, 8'h29, 8'h02, 8'h24));
					snapshots_to_send.push_back(
						snapshot(8'h00, 8'h57, 8'h34, 8'h12, 8'h29, 8'h02, 8'h24));
				end
				4: begin
					cfg_write(CFG_MIN_EPOCH, MIN_EPOCH_RST);
					cfg_write(CFG_MAX_EPOCH, MAX_EPOCH_RST);
				end
				default: begin
					cfg_write(CFG_MIN_EPOCH, MIN_EPOCH_RST + $urandom_range(1_500_000_000));
					cfg_write(CFG_MAX_EPOCH, EPOCH_ALL_ONES);
				end
			endcase
			queue_random(RANDOM_PER_PHASE);
			if (phase == 4) begin
				// long receiver stall so the pipeline backs up into the input
				@(posedge clk);
				rx_hold <= 1'b1;
				repeat (300) @(posedge clk);
				rx_hold <= 1'b0;
			end
		end

		wait_idle();
		if (errors == 0)
			$display("[bcd_clock_to_epoch_core] OK");
		else
			$display("[bcd_clock_to_epoch_core] ERROR");
		$finish;
	end

endmodule
